// ===== hw/rtl/btm_pkg.sv =====
// btm_pkg: shared types, constants and opcodes of the binary template match unit
// no dependencies; imported by the interfaces and every module of the block
`default_nettype none

package btm_pkg;

    localparam int SIDE_DEFAULT = 32;

    localparam int WEIGHT_W = 8;
    localparam int SCORE_W  = 18;
    localparam int COORD_W  = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX    = 8'd255;
    localparam logic [SCORE_W-1:0]  SCORE_MAX     = 18'd261120;
    localparam logic [WEIGHT_W-1:0] REWARD_RESET  = 8'd10;
    localparam logic [WEIGHT_W-1:0] PENALTY_RESET = 8'd50;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_SCORE = 2'd2;
    localparam logic [1:0] OP_TRAIN = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_REWARD  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PENALTY = 1'b1;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [COORD_W-1:0]  coord_x;
        logic [COORD_W-1:0]  coord_y;
        logic                pixel_on;
        logic [WEIGHT_W-1:0] weight_in;
        logic                last_pixel;
    } in_item_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight_out;
        logic [SCORE_W-1:0]  score_total;
        logic                score_done;
    } out_item_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] reward_step;
        logic [WEIGHT_W-1:0] penalty_step;
    } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/btm_in_if.sv =====
// btm_in_if: valid/ready channel carrying one input item
// depends on btm_pkg
`default_nettype none

interface btm_in_if;
    import btm_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/btm_out_if.sv =====
// btm_out_if: valid/ready channel carrying one result item
// depends on btm_pkg
`default_nettype none

interface btm_out_if;
    import btm_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/btm_cfg.sv =====
// btm_cfg: reward and penalty step registers behind the plain write port
// depends on btm_pkg
`default_nettype none

module btm_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wen,
    input  wire logic [btm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [btm_pkg::WEIGHT_W-1:0]     cfg_wdata,
    output btm_pkg::cfg_t                         cfg
);
    import btm_pkg::*;

    logic [WEIGHT_W-1:0] reward_reg;
    logic [WEIGHT_W-1:0] reward_next;
    logic [WEIGHT_W-1:0] penalty_reg;
    logic [WEIGHT_W-1:0] penalty_next;

    always_comb
    begin
        reward_next  = reward_reg;
        penalty_next = penalty_reg;
        if (cfg_wen)
        begin
            case (cfg_index)
                CFG_REWARD:  reward_next  = cfg_wdata;
                CFG_PENALTY: penalty_next = cfg_wdata;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reward_reg  <= REWARD_RESET;
            penalty_reg <= PENALTY_RESET;
        end
        else
        begin
            reward_reg  <= reward_next;
            penalty_reg <= penalty_next;
        end
    end

    assign cfg.reward_step  = reward_reg;
    assign cfg.penalty_step = penalty_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/btm_wmem.sv =====
// btm_wmem: weight table, one write port and one read port with registered data
// depends on btm_pkg
`default_nettype none

module btm_wmem #(
    parameter int DEPTH = btm_pkg::SIDE_DEFAULT * btm_pkg::SIDE_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [AW-1:0]                 wr_addr,
    input  wire logic [btm_pkg::WEIGHT_W-1:0]  wr_data,
    input  wire logic                          rd_en,
    input  wire logic [AW-1:0]                 rd_addr,
    output logic [btm_pkg::WEIGHT_W-1:0]       rd_data
);
    import btm_pkg::*;

    logic [WEIGHT_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/btm_core.sv =====
// btm_core: item sequencing, weight read-modify-write, score accumulation, result register
// depends on btm_pkg, btm_in_if, btm_out_if
`default_nettype none

module btm_core #(
    parameter int SIDE = btm_pkg::SIDE_DEFAULT,
    parameter int AW   = $clog2(SIDE * SIDE)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    btm_in_if.sink                             item,
    btm_out_if.source                          result,
    input  wire btm_pkg::cfg_t                 cfg,
    output logic                               rd_en,
    output logic [AW-1:0]                      rd_addr,
    input  wire logic [btm_pkg::WEIGHT_W-1:0]  rd_data,
    output logic                               wr_en,
    output logic [AW-1:0]                      wr_addr,
    output logic [btm_pkg::WEIGHT_W-1:0]       wr_data
);
    import btm_pkg::*;

    localparam int XW = (SIDE > 1) ? $clog2(SIDE) : 1;
    localparam logic [COORD_W-1:0] SIDE_C = COORD_W'(SIDE);
    localparam logic [AW-1:0]      SIDE_A = AW'(SIDE);

    // item in flight
    logic                busy_reg;
    logic                busy_next;
    logic [1:0]          op_reg;
    logic                pix_reg;
    logic [WEIGHT_W-1:0] win_reg;
    logic                last_reg;
    logic                inr_reg;
    logic [AW-1:0]       addr_reg;

    logic [SCORE_W-1:0]  acc_reg;
    logic [SCORE_W-1:0]  acc_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    out_item_t           out_data_reg;
    out_item_t           out_data_next;

    logic                accept;
    logic                advance;
    logic                in_range;
    logic [AW-1:0]       addr;

    logic [WEIGHT_W-1:0] w;
    logic [WEIGHT_W:0]   up_sum;
    logic [WEIGHT_W-1:0] train_w;
    logic [WEIGHT_W-1:0] add_w;
    logic [SCORE_W:0]    score_sum;
    logic [SCORE_W-1:0]  score_sat;

    assign item.ready = !busy_reg;
    assign accept     = item.valid && !busy_reg;
    assign advance    = busy_reg && (!out_valid_reg || result.ready);

    assign in_range = (item.data.coord_x < SIDE_C) && (item.data.coord_y < SIDE_C);
    assign addr     = AW'(AW'(item.data.coord_x[XW-1:0]) * SIDE_A)
                    + AW'(item.data.coord_y[XW-1:0]);

    assign rd_en   = accept;
    assign rd_addr = addr;

    // weight arithmetic
    assign w       = inr_reg ? rd_data : '0;
    assign up_sum  = {1'b0, w} + {1'b0, cfg.reward_step};

    always_comb
    begin
        if (pix_reg)
        begin
            train_w = up_sum[WEIGHT_W] ? WEIGHT_MAX : up_sum[WEIGHT_W-1:0];
        end
        else
        begin
            train_w = (w > cfg.penalty_step) ? (w - cfg.penalty_step) : '0;
        end
    end

    assign add_w     = pix_reg ? w : (WEIGHT_MAX - w);
    assign score_sum = {1'b0, acc_reg} + (SCORE_W + 1)'(add_w);
    assign score_sat = (score_sum > {1'b0, SCORE_MAX}) ? SCORE_MAX : score_sum[SCORE_W-1:0];

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = win_reg;
        acc_next = acc_reg;
        out_data_next = out_data_reg;
        if (advance)
        begin
            out_data_next.score_total = acc_reg;
            out_data_next.score_done  = 1'b0;
            case (op_reg)
                OP_LOAD:
                begin
                    wr_en   = inr_reg;
                    wr_data = win_reg;
                    out_data_next.weight_out = inr_reg ? win_reg : '0;
                end
                OP_READ:
                begin
                    out_data_next.weight_out = w;
                end
                OP_SCORE:
                begin
                    out_data_next.weight_out  = w;
                    out_data_next.score_total = score_sat;
                    out_data_next.score_done  = last_reg;
                    acc_next = last_reg ? '0 : score_sat;
                end
                OP_TRAIN:
                begin
                    wr_en   = inr_reg;
                    wr_data = train_w;
                    out_data_next.weight_out = inr_reg ? train_w : '0;
                end
                default:
                begin
                    out_data_next.weight_out = w;
                end
            endcase
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (advance)
        begin
            busy_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= item.data.opcode;
            pix_reg  <= item.data.pixel_on;
            win_reg  <= item.data.weight_in;
            last_reg <= item.data.last_pixel;
            inr_reg  <= in_range;
            addr_reg <= addr;
        end
        out_data_reg <= out_data_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/binary_template_match_train_unit.sv =====
// Binary template match and train unit. Keeps a SIDE x SIDE table of 8-bit weights in
// one synchronous memory and serves load, read, score and train items, one result beat
// per item. Each item first reads the weight memory, whose read data is registered,
// then modifies, writes back and loads the result register once that is free. The
// next item is taken as soon as the previous one has moved to the result register.
// Weights not yet written read back as whatever the memory holds. Reward and penalty
// steps are to be written through the cfg port only while the unit is idle; the block
// itself does not enforce this.
// depends on btm_pkg, btm_in_if, btm_out_if, btm_cfg, btm_wmem, btm_core
`default_nettype none

module binary_template_match_train_unit #(
    parameter int SIDE = btm_pkg::SIDE_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    btm_in_if.sink                              item,
    btm_out_if.source                           result,
    input  wire logic                           cfg_wen,
    input  wire logic [btm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [btm_pkg::WEIGHT_W-1:0]   cfg_wdata
);
    import btm_pkg::*;

    localparam int DEPTH = SIDE * SIDE;
    localparam int AW    = $clog2(DEPTH);

    cfg_t                cfg;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [WEIGHT_W-1:0] rd_data;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [WEIGHT_W-1:0] wr_data;

    btm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    btm_wmem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_wmem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    btm_core #(
        .SIDE (SIDE),
        .AW   (AW)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .result  (result),
        .cfg     (cfg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule

`default_nettype wire
